// ===== rtl/core/chr_pkg.sv =====
// Shared constants, word types and sequencer states of the cubic Hermite resampler.
`timescale 1ns / 1ps

package chr_pkg;

  // Sizes of the point store and of the output index range
  localparam int MAX_POINTS  = 256;
  localparam int MAX_OUTPUTS = 4096;
  localparam int PT_AW       = $clog2(MAX_POINTS);

  // Reset values of the configuration registers
  localparam logic [8:0]  POINT_COUNT_RST  = 9'd16;
  localparam logic [12:0] OUTPUT_COUNT_RST = 13'd4096;

  // Clamp limits
  localparam logic [8:0]  POINT_COUNT_MIN  = 9'd2;
  localparam logic [8:0]  POINT_COUNT_MAX  = 9'(MAX_POINTS);
  localparam logic [12:0] OUTPUT_COUNT_MIN = 13'd2;
  localparam logic [12:0] OUTPUT_COUNT_MAX = 13'(MAX_OUTPUTS);

  // Register indexes on the configuration port
  localparam logic CFG_POINT_COUNT  = 1'b0;
  localparam logic CFG_OUTPUT_COUNT = 1'b1;

  // Item functions
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Quotient bits: 8 integer bits plus a 16-bit fraction
  localparam int DIV_STEPS = 24;

  typedef struct packed {
    logic        func;
    logic [7:0]  point_index;
    logic [15:0] point_value;
    logic [11:0] out_index;
  } in_word_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [11:0] sample_index;
    logic        index_error;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END_RD,
    ST_END_OUT,
    ST_MULT,
    ST_DIV_LD,
    ST_DIV,
    ST_RD,
    ST_COEF,
    ST_M1,
    ST_A1,
    ST_M2,
    ST_A2,
    ST_M3,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/core/chr_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module chr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle: optional write, and a read of the old word into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cubic_hermite_resampler_unit.sv =====
// Top level of the cubic Hermite resampler: sequencer, shared multiplier, divider, point store.
`timescale 1ns / 1ps

// A store word (func 0) writes its point, leaves the unit idle and gives no result. A query word (func 1)
// gives exactly one result word, shown for one cycle with out_strobe; results
// cannot be held off. An index at or beyond the clamped output count answers in the
// cycle after the accept; the two end indexes read an end point in ST_END_RD and
// answer from ST_END_OUT. Any other query keeps busy high while it runs: it does the
// 24-step shift-subtract divide that maps the index to a point position, reads the
// point store through its single read port (two or four reads) and uses the one
// 21x17 multiplier, once for the index product and then once (linear, on the first
// and last segments) or three times (cubic) in turn.
// New configuration applies to the next query. No clearing pass after reset.
module cubic_hermite_resampler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  chr_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output chr_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data
);

  chr_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [8:0]  point_count_r;
  logic [12:0] output_count_r;

  // Query context
  logic [11:0] j_r, j_nxt;
  logic [7:0]  nm1_r, nm1_nxt;
  logic [11:0] den_r, den_nxt;
  logic [7:0]  end_addr_r, end_addr_nxt;

  // Divider
  logic [11:0] rem_r, rem_nxt;
  logic [23:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // Point fetch
  logic [2:0]  rd_cnt_r, rd_cnt_nxt;
  logic [15:0] pt_r [4];
  logic [15:0] pt_nxt [4];

  // Polynomial datapath
  logic signed [20:0] mcand_r, mcand_nxt;
  logic signed [20:0] c1_r, c1_nxt;
  logic signed [20:0] c2_r, c2_nxt;
  logic [15:0]        base_r, base_nxt;
  logic signed [37:0] prod_r, prod_nxt;

  // Output
  logic               out_strobe_r, out_strobe_nxt;
  chr_pkg::out_word_t out_word_r, out_word_nxt;

  // RAM port
  logic                        ram_we;
  logic [chr_pkg::PT_AW-1:0]   ram_addr;
  logic [15:0]                 ram_rdata;

  // Combinational helpers
  logic [8:0]  n_c;
  logic [12:0] m_c;
  logic        accept;
  logic [12:0] rem_sh;
  logic        rem_ge;
  logic [7:0]  seg_i;
  logic [15:0] frac;
  logic        lin;
  logic [7:0]  rd_base;
  logic [2:0]  rd_last;
  logic signed [20:0] q0, q1, q2, q3;
  logic signed [20:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [37:0] mul_p;
  logic signed [37:0] r16_sum, r17_sum;
  logic signed [21:0] r16;
  logic signed [20:0] r17;
  logic signed [21:0] acc_sum;
  logic signed [22:0] fin_sum;
  logic [15:0]        fin_sat;

  chr_ram #(
    .WIDTH(16),
    .DEPTH(chr_pkg::MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_word.point_value),
    .rdata(ram_rdata)
  );

  assign accept = start && (state_r == chr_pkg::ST_IDLE);
  assign busy   = (state_r != chr_pkg::ST_IDLE);

  // Clamp the counts into their usable ranges
  always_comb begin
    if (point_count_r < chr_pkg::POINT_COUNT_MIN) begin
      n_c = chr_pkg::POINT_COUNT_MIN;
    end else if (point_count_r > chr_pkg::POINT_COUNT_MAX) begin
      n_c = chr_pkg::POINT_COUNT_MAX;
    end else begin
      n_c = point_count_r;
    end
    if (output_count_r < chr_pkg::OUTPUT_COUNT_MIN) begin
      m_c = chr_pkg::OUTPUT_COUNT_MIN;
    end else if (output_count_r > chr_pkg::OUTPUT_COUNT_MAX) begin
      m_c = chr_pkg::OUTPUT_COUNT_MAX;
    end else begin
      m_c = output_count_r;
    end
  end

  // Divide step: shift in one dividend bit, subtract if it fits
  assign rem_sh = {rem_r, quo_r[23]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  // Segment and fraction from the quotient
  assign seg_i   = quo_r[23:16];
  assign frac    = quo_r[15:0];
  assign lin     = (seg_i == 8'd0) || (seg_i == nm1_r - 8'd1);
  assign rd_base = lin ? seg_i : seg_i - 8'd1;
  assign rd_last = lin ? 3'd2 : 3'd4;

  // Fetched points, widened for the coefficient sums
  assign q0 = {5'b0, pt_r[0]};
  assign q1 = {5'b0, pt_r[1]};
  assign q2 = {5'b0, pt_r[2]};
  assign q3 = {5'b0, pt_r[3]};

  // Shared multiplier: index times (n-1), then coefficient times fraction
  always_comb begin
    if (state_r == chr_pkg::ST_MULT) begin
      mul_a = {9'b0, j_r};
      mul_b = {9'b0, nm1_r};
    end else begin
      mul_a = mcand_r;
      mul_b = {1'b0, frac};
    end
  end
  assign mul_p = mul_a * mul_b;

  // Round half up, then arithmetic shift by 16 or 17
  assign r16_sum = prod_r + 38'sh8000;
  assign r17_sum = prod_r + 38'sh10000;
  assign r16     = r16_sum[37:16];
  assign r17     = r17_sum[37:17];

  // Horner accumulate: c + rnd(prev * F, 16)
  always_comb begin
    if (state_r == chr_pkg::ST_A1) begin
      acc_sum = {c2_r[20], c2_r} + r16;
    end else begin
      acc_sum = {c1_r[20], c1_r} + r16;
    end
  end

  // Final sum and saturation
  always_comb begin
    if (lin) begin
      fin_sum = {7'b0, base_r} + {r16[21], r16};
    end else begin
      fin_sum = {7'b0, base_r} + {{2{r17[20]}}, r17};
    end
    if (fin_sum[22]) begin
      fin_sat = 16'd0;
    end else if (|fin_sum[21:16]) begin
      fin_sat = 16'hFFFF;
    end else begin
      fin_sat = fin_sum[15:0];
    end
  end

  // Sequencer: next state, datapath loads and output
  always_comb begin
    state_nxt      = state_r;
    j_nxt          = j_r;
    nm1_nxt        = nm1_r;
    den_nxt        = den_r;
    end_addr_nxt   = end_addr_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    rd_cnt_nxt     = rd_cnt_r;
    pt_nxt         = pt_r;
    mcand_nxt      = mcand_r;
    c1_nxt         = c1_r;
    c2_nxt         = c2_r;
    base_nxt       = base_r;
    prod_nxt       = prod_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    ram_we         = 1'b0;
    ram_addr       = in_word.point_index;

    case (state_r)
      chr_pkg::ST_IDLE: begin
        if (accept) begin
          j_nxt        = in_word.out_index;
          nm1_nxt      = 8'(n_c - 9'd1);
          den_nxt      = 12'(m_c - 13'd1);
          end_addr_nxt = (in_word.out_index == 12'd0) ? 8'd0 : 8'(n_c - 9'd1);
          if (in_word.func == chr_pkg::FUNC_STORE) begin
            ram_we = 1'b1;
          end else if ({1'b0, in_word.out_index} >= m_c) begin
            out_strobe_nxt            = 1'b1;
            out_word_nxt.sample       = 16'd0;
            out_word_nxt.sample_index = in_word.out_index;
            out_word_nxt.index_error  = 1'b1;
          end else if ((in_word.out_index == 12'd0) ||
                       (in_word.out_index == 12'(m_c - 13'd1))) begin
            state_nxt = chr_pkg::ST_END_RD;
          end else begin
            state_nxt = chr_pkg::ST_MULT;
          end
        end
      end

      // End indexes copy an end point
      chr_pkg::ST_END_RD: begin
        ram_addr  = end_addr_r;
        state_nxt = chr_pkg::ST_END_OUT;
      end

      chr_pkg::ST_END_OUT: begin
        out_strobe_nxt            = 1'b1;
        out_word_nxt.sample       = ram_rdata;
        out_word_nxt.sample_index = j_r;
        out_word_nxt.index_error  = 1'b0;
        state_nxt                 = chr_pkg::ST_IDLE;
      end

      // t = j * (n-1)
      chr_pkg::ST_MULT: begin
        prod_nxt  = mul_p;
        state_nxt = chr_pkg::ST_DIV_LD;
      end

      // Upper bits of t start below the divisor since t/den < 256
      chr_pkg::ST_DIV_LD: begin
        rem_nxt   = prod_r[19:8];
        quo_nxt   = {prod_r[7:0], 16'd0};
        cnt_nxt   = 5'd0;
        state_nxt = chr_pkg::ST_DIV;
      end

      // (t << 16) / (m-1), one quotient bit per cycle
      chr_pkg::ST_DIV: begin
        rem_nxt = rem_ge ? 12'(rem_sh - {1'b0, den_r}) : rem_sh[11:0];
        quo_nxt = {quo_r[22:0], rem_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(chr_pkg::DIV_STEPS - 1)) begin
          rd_cnt_nxt = 3'd0;
          state_nxt  = chr_pkg::ST_RD;
        end
      end

      // Fetch two or four neighboring points, one per cycle
      chr_pkg::ST_RD: begin
        ram_addr = rd_base + {6'd0, rd_cnt_r[1:0]};
        if (rd_cnt_r != 3'd0) begin
          pt_nxt[2'(rd_cnt_r - 3'd1)] = ram_rdata;
        end
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (rd_cnt_r == rd_last) begin
          state_nxt = chr_pkg::ST_COEF;
        end
      end

      // Coefficients; the linear case goes straight to the last multiply
      chr_pkg::ST_COEF: begin
        if (lin) begin
          mcand_nxt = q1 - q0;
          base_nxt  = pt_r[0];
          state_nxt = chr_pkg::ST_M3;
        end else begin
          mcand_nxt = q3 - q0 + (q1 <<< 1) + q1 - (q2 <<< 1) - q2;
          c2_nxt    = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
          c1_nxt    = q2 - q0;
          base_nxt  = pt_r[1];
          state_nxt = chr_pkg::ST_M1;
        end
      end

      chr_pkg::ST_M1: begin
        prod_nxt  = mul_p;
        state_nxt = chr_pkg::ST_A1;
      end

      chr_pkg::ST_A1: begin
        mcand_nxt = acc_sum[20:0];
        state_nxt = chr_pkg::ST_M2;
      end

      chr_pkg::ST_M2: begin
        prod_nxt  = mul_p;
        state_nxt = chr_pkg::ST_A2;
      end

      chr_pkg::ST_A2: begin
        mcand_nxt = acc_sum[20:0];
        state_nxt = chr_pkg::ST_M3;
      end

      chr_pkg::ST_M3: begin
        prod_nxt  = mul_p;
        state_nxt = chr_pkg::ST_FIN;
      end

      chr_pkg::ST_FIN: begin
        out_strobe_nxt            = 1'b1;
        out_word_nxt.sample       = fin_sat;
        out_word_nxt.sample_index = j_r;
        out_word_nxt.index_error  = 1'b0;
        state_nxt                 = chr_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = chr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= chr_pkg::ST_IDLE;
      out_strobe_r   <= 1'b0;
      point_count_r  <= chr_pkg::POINT_COUNT_RST;
      output_count_r <= chr_pkg::OUTPUT_COUNT_RST;
      cnt_r          <= 5'd0;
      rd_cnt_r       <= 3'd0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      cnt_r        <= cnt_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          chr_pkg::CFG_POINT_COUNT:  point_count_r  <= cfg_data[8:0];
          chr_pkg::CFG_OUTPUT_COUNT: output_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    nm1_r      <= nm1_nxt;
    den_r      <= den_nxt;
    end_addr_r <= end_addr_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    pt_r       <= pt_nxt;
    mcand_r    <= mcand_nxt;
    c1_r       <= c1_nxt;
    c2_r       <= c2_nxt;
    base_r     <= base_nxt;
    prod_r     <= prod_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule
